/* design/sge_pkg.sv */
// Shared types and constants for the scaled glyph row expander.
// No dependencies; every other design file except sge_ifs imports this package.
package sge_pkg;

	localparam int XW = 13;
	localparam int YW = 14;
	localparam int WINW = 11;
	localparam int ROWW = 64;
	localparam int LENW = 7;
	localparam int CFG_IDXW = 3;
	localparam int CFG_DATAW = 11;

	localparam logic [CFG_IDXW-1:0] REG_X_SCALE = 3'd0;
	localparam logic [CFG_IDXW-1:0] REG_Y_SCALE = 3'd1;
	localparam logic [CFG_IDXW-1:0] REG_TRANSPARENT = 3'd2;
	localparam logic [CFG_IDXW-1:0] REG_WIN_TOP = 3'd3;
	localparam logic [CFG_IDXW-1:0] REG_WIN_BOTTOM = 3'd4;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic [WINW-1:0] lo;
		logic [WINW-1:0] hi;
		logic [LENW-1:0] len;
		logic cut;
		logic [ROWW-1:0] fg;
		logic [ROWW-1:0] wr;
		logic last;
	} sge_item_t;

endpackage

/* design/sge_ifs.sv */
// Channel interfaces: glyph row input, scanline span output, register writes.
// Field widths are written out here, not taken from sge_pkg.
interface sge_row_if;
	logic valid;
	logic ready;
	logic [10:0] origin_x;
	logic [10:0] origin_y;
	logic signed [7:0] x_offset;
	logic signed [7:0] y_offset;
	logic [5:0] row_index;
	logic [6:0] glyph_width;
	logic [63:0] row_bits;
	logic last_row;

	modport source (output valid, origin_x, origin_y, x_offset, y_offset, row_index,
		glyph_width, row_bits, last_row, input ready);
	modport sink (input valid, origin_x, origin_y, x_offset, y_offset, row_index,
		glyph_width, row_bits, last_row, output ready);
endinterface

interface sge_span_if #(parameter int COORD_BITS = 12);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] line_x;
	logic signed [COORD_BITS-1:0] line_y;
	logic [6:0] span_len;
	logic [63:0] fg_mask;
	logic [63:0] write_mask;
	logic span_cut;
	logic glyph_done;
	logic last_line;

	modport source (output valid, line_x, line_y, span_len, fg_mask, write_mask, span_cut,
		glyph_done, last_line, input ready);
	modport sink (input valid, line_x, line_y, span_len, fg_mask, write_mask, span_cut,
		glyph_done, last_line, output ready);
endinterface

interface sge_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [10:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/scaled_glyph_row_expander_core.sv */
// Top level of the scaled glyph row expander: front end, row queue and back end.
// Depends on sge_pkg, sge_ifs, sge_front, sge_fifo and sge_back.
//
// Channel   Role    Transaction
// in_row    sink    one glyph bitmap row with position and flags
// out_span  source  one visible scanline span with masks
// cfg       sink    one register write, index and data
//
// A row is registered in the front stage, where it is expanded and tested against the
// window, then waits in a four-entry queue. The back end emits one scanline per cycle
// while the output is ready and the queue holds a row; a row yields one span per
// visible scanline, at most eight. A fully clipped row is dropped and yields nothing.
// Reset clears all control state and loads the register defaults.
// A stalled output holds its span while the front keeps filling the queue.
module scaled_glyph_row_expander_core #(
	parameter int MAX_SPAN = 64,
	parameter int MAX_SCALE = 8,
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	sge_row_if.sink in_row,
	sge_span_if.source out_span,
	sge_cfg_if.sink cfg
);
	import sge_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	sge_item_t push_item;
	sge_item_t head_item;

	sge_front #(
		.MAX_SPAN(MAX_SPAN),
		.MAX_SCALE(MAX_SCALE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_row(in_row),
		.cfg(cfg),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(push_item)
	);

	sge_fifo #(
		.DEPTH(4)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din(push_item),
		.full(q_full),
		.pop(q_pop),
		.dout(head_item),
		.empty(q_empty)
	);

	sge_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_item(head_item),
		.q_pop(q_pop),
		.out_span(out_span)
	);
endmodule

/* design/sge_fifo.sv */
// Small flop-based queue of classified rows between front and back.
// Depends on sge_pkg for the item type.
module sge_fifo #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sge_pkg::sge_item_t din,
	output logic full,
	input  logic pop,
	output sge_pkg::sge_item_t dout,
	output logic empty
);
	import sge_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sge_item_t mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end
endmodule

/* design/sge_front.sv */
// Front end: register file, row expansion into masks, and vertical window classification.
// Depends on sge_pkg and the channel interfaces; feeds sge_fifo.
module sge_front #(
	parameter int MAX_SPAN = 64,
	parameter int MAX_SCALE = 8
) (
	input  logic clk,
	input  logic arst_n,
	sge_row_if.sink in_row,
	sge_cfg_if.sink cfg,
	input  logic q_full,
	output logic q_push,
	output sge_pkg::sge_item_t q_item
);
	import sge_pkg::*;

	logic [3:0] x_scale_q;
	logic [3:0] y_scale_q;
	logic transparent_q;
	logic [WINW-1:0] win_top_q;
	logic [WINW-1:0] win_bottom_q;

	logic [3:0] xs;
	logic [3:0] ys;
	logic [6:0] gw;
	logic [10:0] full_w;
	logic cut_d;
	logic [LENW-1:0] len_d;
	logic [MAX_SCALE-1:0][ROWW-1:0] expd_by_scale;
	logic [ROWW-1:0] expd;
	logic [ROWW-1:0] lmask;
	logic [ROWW-1:0] fg_d;
	logic [9:0] row_prod;
	logic signed [XW-1:0] x_d;
	logic signed [YW-1:0] ybase_d;

	logic v_s1;
	logic signed [XW-1:0] x_s1;
	logic signed [YW-1:0] ybase_s1;
	logic [3:0] ys_s1;
	logic [LENW-1:0] len_s1;
	logic cut_s1;
	logic [ROWW-1:0] fg_s1;
	logic [ROWW-1:0] wr_s1;
	logic last_s1;

	logic signed [YW-1:0] ytop;
	logic signed [YW-1:0] lo;
	logic signed [YW-1:0] hi;
	logic keep;
	logic advance;
	logic in_fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= 4'd1;
			y_scale_q <= 4'd1;
			transparent_q <= 1'b0;
			win_top_q <= '0;
			win_bottom_q <= '1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_X_SCALE: x_scale_q <= cfg.data[3:0];
				REG_Y_SCALE: y_scale_q <= cfg.data[3:0];
				REG_TRANSPARENT: transparent_q <= cfg.data[0];
				REG_WIN_TOP: win_top_q <= cfg.data[WINW-1:0];
				REG_WIN_BOTTOM: win_bottom_q <= cfg.data[WINW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		xs = x_scale_q;
		if (x_scale_q == 4'd0) xs = 4'd1;
		else if (x_scale_q > 4'(MAX_SCALE)) xs = 4'(MAX_SCALE);
		ys = y_scale_q;
		if (y_scale_q == 4'd0) ys = 4'd1;
		else if (y_scale_q > 4'(MAX_SCALE)) ys = 4'(MAX_SCALE);
		gw = (in_row.glyph_width > 7'd64) ? 7'd64 : in_row.glyph_width;
		full_w = 11'(gw) * 11'(xs);
		cut_d = full_w > 11'(MAX_SPAN);
		len_d = cut_d ? LENW'(MAX_SPAN) : full_w[LENW-1:0];
	end

	for (genvar k = 0; k < MAX_SCALE; k++) begin : g_scale
		for (genvar i = 0; i < ROWW; i++) begin : g_bit
			localparam int SRC = ROWW - 1 - i / (k + 1);
			assign expd_by_scale[k][i] = in_row.row_bits[SRC];
		end
	end

	always_comb begin
		expd = '0;
		for (int k = 1; k <= MAX_SCALE; k++) begin
			if (xs == 4'(k)) begin
				expd = expd_by_scale[k - 1];
			end
		end
		for (int i = 0; i < ROWW; i++) begin
			lmask[i] = 7'(i) < len_d;
		end
		fg_d = expd & lmask;
	end

	assign row_prod = 10'(in_row.row_index) * 10'(ys);
	assign x_d = $signed({2'b00, in_row.origin_x}) + XW'(in_row.x_offset);
	assign ybase_d = $signed({3'b000, in_row.origin_y}) + YW'(in_row.y_offset)
		+ $signed({4'b0000, row_prod});

	assign ytop = ybase_s1 + $signed({10'd0, ys_s1}) - YW'(1);
	assign lo = (ybase_s1 > $signed({3'b000, win_top_q})) ? ybase_s1
		: $signed({3'b000, win_top_q});
	assign hi = (ytop < $signed({3'b000, win_bottom_q})) ? ytop
		: $signed({3'b000, win_bottom_q});
	assign keep = lo <= hi;

	assign q_push = v_s1 && keep && !q_full;
	assign advance = v_s1 && (!keep || !q_full);
	assign in_row.ready = !v_s1 || advance;
	assign in_fire = in_row.valid && in_row.ready;

	always_comb begin
		q_item.x = x_s1;
		q_item.lo = lo[WINW-1:0];
		q_item.hi = hi[WINW-1:0];
		q_item.len = len_s1;
		q_item.cut = cut_s1;
		q_item.fg = fg_s1;
		q_item.wr = wr_s1;
		q_item.last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_row.ready) begin
			v_s1 <= in_row.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_s1 <= x_d;
			ybase_s1 <= ybase_d;
			ys_s1 <= ys;
			len_s1 <= len_d;
			cut_s1 <= cut_d;
			fg_s1 <= fg_d;
			wr_s1 <= transparent_q ? fg_d : lmask;
			last_s1 <= in_row.last_row;
		end
	end
endmodule

/* design/sge_back.sv */
// Back end: walks the visible scanlines of the queued row and drives the output register.
// Depends on sge_pkg and the span interface; reads from sge_fifo.
module sge_back #(
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  sge_pkg::sge_item_t q_item,
	output logic q_pop,
	sge_span_if.source out_span
);
	import sge_pkg::*;

	logic started_q;
	logic [WINW-1:0] y_q;
	logic [WINW-1:0] y_cur;
	logic fire;
	logic at_end;
	logic ovalid_q;
	logic signed [COORD_BITS-1:0] line_x_q;
	logic signed [COORD_BITS-1:0] line_y_q;
	logic [LENW-1:0] span_len_q;
	logic [ROWW-1:0] fg_q;
	logic [ROWW-1:0] wr_q;
	logic cut_q;
	logic done_q;
	logic last_q;

	assign y_cur = started_q ? y_q : q_item.lo;
	assign fire = !q_empty && (!ovalid_q || out_span.ready);
	assign at_end = y_cur == q_item.hi;
	assign q_pop = fire && at_end;

	assign out_span.valid = ovalid_q;
	assign out_span.line_x = line_x_q;
	assign out_span.line_y = line_y_q;
	assign out_span.span_len = span_len_q;
	assign out_span.fg_mask = fg_q;
	assign out_span.write_mask = wr_q;
	assign out_span.span_cut = cut_q;
	assign out_span.glyph_done = done_q;
	assign out_span.last_line = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			y_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (fire) begin
				ovalid_q <= 1'b1;
				started_q <= !at_end;
				y_q <= y_cur + 1'b1;
			end else if (out_span.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			line_x_q <= COORD_BITS'(q_item.x);
			line_y_q <= COORD_BITS'({1'b0, y_cur});
			span_len_q <= q_item.len;
			fg_q <= q_item.fg;
			wr_q <= q_item.wr;
			cut_q <= q_item.cut;
			done_q <= at_end && q_item.last;
			last_q <= at_end;
		end
	end
endmodule
